>>> sv/phg_pkg.sv
// Shared constants, widths and types of the plasma hue generator.
`default_nettype none

package phg_pkg;

  localparam int unsigned DEF_COLUMNS = 16;
  localparam int unsigned DEF_ROWS    = 16;

  localparam int unsigned COORD_W = 4;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned HUE_W   = 16;
  localparam int unsigned ABSP_W  = 7;
  localparam int unsigned PK_W    = 20;
  localparam int unsigned NXY_W   = 24;
  localparam int unsigned XY_W    = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned ANG_W   = 13;
  localparam int unsigned U2_W    = 32;
  localparam int unsigned T_W     = 31;
  localparam int unsigned SINE_W  = 16;

  localparam int unsigned P_FULL = 100;

  localparam logic [STEP_W-1:0]  STEP_LAST = 8'd200;
  localparam logic [HUE_W-1:0]   SHIFT_INC = 16'd2048;
  localparam logic signed [9:0]  STEP_MID  = 10'sd200;
  localparam logic signed [9:0]  P_FULL_S  = 10'sd100;
  localparam logic [12:0]        SCALE_Q12 = 13'd7721;

  localparam logic [21:0] SAT_POS     = 22'd32767;
  localparam logic [21:0] SAT_NEG_MAG = 22'd32768;
  localparam logic [15:0] ARG_MAX     = 16'h7fff;
  localparam logic [15:0] ARG_MIN     = 16'h8000;

  localparam logic signed [16:0] TWO_PI_Q12    = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_X2_Q12 = 17'sd51472;
  localparam logic signed [16:0] PI_Q12        = 17'sd12868;
  localparam logic signed [16:0] HALF_PI_Q12   = 17'sd6434;

  localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam int unsigned FIRST_DIV = 110;
  localparam int unsigned HORNER_N  = 4;
  localparam int unsigned HORNER_DIV [HORNER_N] = '{72, 42, 20, 6};

  localparam logic [16:0]         SINE_MAX = 17'd32767;
  localparam logic signed [17:0]  HUE_BIAS = 18'sd98304;
  localparam logic [14:0]         HUE_GAIN = 15'd32767;
  localparam int unsigned         HUE_DIV  = 98304;

  typedef struct packed {
    logic [U2_W-1:0]  u2;
    logic [ANG_W-1:0] ang;
    logic             neg;
    logic [HUE_W-1:0] shift;
  } sine_side_t;

endpackage

`default_nettype wire

>>> sv/phg_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
`default_nettype none

module phg_cdiv #(
  parameter int unsigned DIVISOR = 3,
  parameter int unsigned NUM_W   = 32,
  parameter int unsigned SIDE_W  = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [NUM_W-1:0]  num,
  input  wire  [SIDE_W-1:0] side_in,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic [63:0]      RECIP_WIDE = (64'd1 << NUM_W) / 64'(DIVISOR);
  localparam logic [NUM_W-1:0] RECIP      = RECIP_WIDE[NUM_W-1:0];
  localparam logic [NUM_W-1:0] DIV_N      = NUM_W'(DIVISOR);

  logic               a_valid;
  logic               b_valid;
  logic               a_ready;
  logic               b_ready;
  logic [NUM_W-1:0]   a_num;
  logic [NUM_W-1:0]   a_quo;
  logic [SIDE_W-1:0]  a_side;
  logic [2*NUM_W-1:0] recip_prod;
  logic [2*NUM_W-1:0] back_prod;
  logic [NUM_W-1:0]   rem;

  // The estimate is the true quotient or one below it.
  assign recip_prod = num * RECIP;
  assign back_prod  = a_quo * DIV_N;
  assign rem        = a_num - back_prod[NUM_W-1:0];

  assign b_ready   = !b_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
    if (a_ready && in_valid) begin
      a_num  <= num;
      a_quo  <= recip_prod[2*NUM_W-1:NUM_W];
      a_side <= side_in;
    end
    if (b_ready && a_valid) begin
      quo      <= (rem >= DIV_N) ? a_quo + 1'b1 : a_quo;
      side_out <= a_side;
    end
  end

endmodule

`default_nettype wire

>>> sv/phg_front.sv
// Coordinate scaling, squaring, argument saturation and quadrant folding.
`default_nettype none

module phg_front import phg_pkg::*; #(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [COORD_W-1:0] column,
  input  wire  [COORD_W-1:0] row,
  input  wire  [STEP_W-1:0]  phase_step,
  input  wire  [HUE_W-1:0]   hue_shift,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [ANG_W-1:0]   angle,
  output logic               negate,
  output logic [HUE_W-1:0]   shift_out
);

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s6_ready;

  logic [COORD_W-1:0] s1_col, s1_row, s2_col, s2_row;
  logic [ABSP_W-1:0]  s1_absp;
  logic [PK_W-1:0]    s2_pk;
  logic [NXY_W-1:0]   s3_nx, s3_ny;
  logic [SQ_W-1:0]    s4_x2, s4_y2;
  logic signed [15:0] s5_a;
  logic [HUE_W-1:0]   s1_shift, s2_shift, s3_shift, s4_shift, s5_shift;

  logic signed [9:0] d_s, dist_s, p_s, absp_s;
  logic [PK_W-1:0]   pk_next;
  logic [NXY_W-1:0]  nx_next, ny_next;

  logic              dx_in_ready, dy_in_ready, dx_valid, dy_valid;
  logic [NXY_W-1:0]  qx, qy;
  logic [7:0]        side_hi, side_lo;
  logic [SQ_W-1:0]   x2_next, y2_next;

  logic signed [33:0] dsum;
  logic [33:0]        dmag;
  logic [21:0]        amag;
  logic [15:0]        a_next;

  logic signed [16:0] ae, red, r1, r2;
  logic               neg_next;

  assign d_s    = signed'({1'b0, phase_step, 1'b0}) - STEP_MID;
  assign dist_s = d_s[9] ? -d_s : d_s;
  assign p_s    = P_FULL_S - dist_s;
  assign absp_s = p_s[9] ? -p_s : p_s;

  assign pk_next = s1_absp * SCALE_Q12;
  assign nx_next = s2_col * s2_pk;
  assign ny_next = s2_row * s2_pk;

  assign x2_next = qx[XY_W-1:0] * qx[XY_W-1:0];
  assign y2_next = qy[XY_W-1:0] * qy[XY_W-1:0];

  // Division by 4096 truncates toward zero, then the argument saturates.
  assign dsum = signed'({2'b00, s4_x2}) - signed'({1'b0, s4_y2, 1'b0});
  assign dmag = dsum[33] ? unsigned'(-dsum) : unsigned'(dsum);
  assign amag = dmag[33:12];
  always_comb begin
    if (!dsum[33]) begin
      a_next = (amag > SAT_POS) ? ARG_MAX : amag[15:0];
    end else begin
      a_next = (amag > SAT_NEG_MAG) ? ARG_MIN : 16'(~amag[15:0] + 16'd1);
    end
  end

  // Reduce into one turn, then fold into the first quadrant.
  assign ae = 17'(s5_a);
  always_comb begin
    if (ae < 0) begin
      red = (ae < -TWO_PI_Q12) ? ae + TWO_PI_X2_Q12 : ae + TWO_PI_Q12;
    end else begin
      red = (ae >= TWO_PI_Q12) ? ae - TWO_PI_Q12 : ae;
    end
  end
  assign neg_next = (red >= PI_Q12);
  assign r1 = neg_next ? red - PI_Q12 : red;
  assign r2 = (r1 > HALF_PI_Q12) ? PI_Q12 - r1 : r1;

  assign s6_ready = !s6_valid || out_ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || (dx_in_ready && dy_in_ready);
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign out_valid = s6_valid;

  phg_cdiv #(
    .DIVISOR (P_FULL * COLUMNS),
    .NUM_W   (NXY_W),
    .SIDE_W  (8)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (dx_in_ready),
    .num       (s3_nx),
    .side_in   (s3_shift[15:8]),
    .out_valid (dx_valid),
    .out_ready (s4_ready),
    .quo       (qx),
    .side_out  (side_hi)
  );

  phg_cdiv #(
    .DIVISOR (P_FULL * ROWS),
    .NUM_W   (NXY_W),
    .SIDE_W  (8)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (dy_in_ready),
    .num       (s3_ny),
    .side_in   (s3_shift[7:0]),
    .out_valid (dy_valid),
    .out_ready (s4_ready),
    .quo       (qy),
    .side_out  (side_lo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= dx_valid && dy_valid;
      if (s5_ready) s5_valid <= s4_valid;
      if (s6_ready) s6_valid <= s5_valid;
    end
    if (s1_ready && in_valid) begin
      s1_col   <= column;
      s1_row   <= row;
      s1_absp  <= absp_s[ABSP_W-1:0];
      s1_shift <= hue_shift;
    end
    if (s2_ready && s1_valid) begin
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_pk    <= pk_next;
      s2_shift <= s1_shift;
    end
    if (s3_ready && s2_valid) begin
      s3_nx    <= nx_next;
      s3_ny    <= ny_next;
      s3_shift <= s2_shift;
    end
    if (s4_ready && dx_valid && dy_valid) begin
      s4_x2    <= x2_next;
      s4_y2    <= y2_next;
      s4_shift <= {side_hi, side_lo};
    end
    if (s5_ready && s4_valid) begin
      s5_a     <= signed'(a_next);
      s5_shift <= s4_shift;
    end
    if (s6_ready && s5_valid) begin
      angle     <= r2[ANG_W-1:0];
      negate    <= neg_next;
      shift_out <= s5_shift;
    end
  end

endmodule

`default_nettype wire

>>> sv/phg_sine.sv
// Q1.15 sine of a first-quadrant angle by a pipelined Horner series.
`default_nettype none

module phg_sine import phg_pkg::*; (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [ANG_W-1:0]         angle,
  input  wire                      negate,
  input  wire  [HUE_W-1:0]         shift_in,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [SINE_W-1:0] sine,
  output logic [HUE_W-1:0]         shift_out
);

  logic            q_valid, q_ready, q_div_ready;
  sine_side_t      q_side;
  logic [2*ANG_W-1:0] ang_sq;

  logic            c_valid [HORNER_N+1];
  logic            c_ready [HORNER_N+1];
  logic [U2_W-1:0] c_quo   [HORNER_N+1];
  sine_side_t      c_side  [HORNER_N+1];

  logic            f_ready;
  logic [T_W-1:0]  f_t;
  logic [ANG_W+T_W-1:0] f_prod;
  logic [16:0]     f_mag;
  logic [15:0]     f_clamp;

  assign ang_sq = angle * angle;

  assign q_ready  = !q_valid || q_div_ready;
  assign in_ready = q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_ready) begin
      q_valid <= in_valid;
    end
    if (q_ready && in_valid) begin
      q_side.u2    <= {ang_sq, 6'b000000};
      q_side.ang   <= angle;
      q_side.neg   <= negate;
      q_side.shift <= shift_in;
    end
  end

  phg_cdiv #(
    .DIVISOR (FIRST_DIV),
    .NUM_W   (U2_W),
    .SIDE_W  ($bits(sine_side_t))
  ) u_div_first (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_div_ready),
    .num       (q_side.u2),
    .side_in   (q_side),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .quo       (c_quo[0]),
    .side_out  (c_side[0])
  );

  for (genvar g = 0; g < HORNER_N; g++) begin : g_horner
    logic              m_valid, m_ready, d_ready;
    logic [T_W-1:0]    t_prev;
    logic [U2_W+T_W-1:0] m_prod;
    logic [U2_W-1:0]   m_val;
    sine_side_t        m_side;

    assign t_prev     = ONE_Q30 - c_quo[g][T_W-1:0];
    assign m_prod     = c_side[g].u2 * t_prev;
    assign m_ready    = !m_valid || d_ready;
    assign c_ready[g] = m_ready;

    always_ff @(posedge clk) begin
      if (rst) begin
        m_valid <= 1'b0;
      end else if (m_ready) begin
        m_valid <= c_valid[g];
      end
      if (m_ready && c_valid[g]) begin
        m_val  <= m_prod[U2_W+29:30];
        m_side <= c_side[g];
      end
    end

    phg_cdiv #(
      .DIVISOR (HORNER_DIV[g]),
      .NUM_W   (U2_W),
      .SIDE_W  ($bits(sine_side_t))
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (m_valid),
      .in_ready  (d_ready),
      .num       (m_val),
      .side_in   (m_side),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .quo       (c_quo[g+1]),
      .side_out  (c_side[g+1])
    );
  end

  // The sine is angle * t with t in Q1.30, taken down to Q1.15.
  assign f_t     = ONE_Q30 - c_quo[HORNER_N][T_W-1:0];
  assign f_prod  = c_side[HORNER_N].ang * f_t;
  assign f_mag   = f_prod[43:27];
  assign f_clamp = (f_mag > SINE_MAX) ? SINE_MAX[15:0] : f_mag[15:0];

  assign f_ready           = !out_valid || out_ready;
  assign c_ready[HORNER_N] = f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (f_ready) begin
      out_valid <= c_valid[HORNER_N];
    end
    if (f_ready && c_valid[HORNER_N]) begin
      sine      <= c_side[HORNER_N].neg ? -signed'(f_clamp) : signed'(f_clamp);
      shift_out <= c_side[HORNER_N].shift;
    end
  end

endmodule

`default_nettype wire

>>> sv/plasma_hue_generator.sv
// Top level of the plasma hue generator: frame phase state, hue scaling, output register.
//
//   channel  valid        stall        payload
//   -------  -----------  -----------  ----------------------------
//   pixel    pixel_valid  pixel_stall  column, row, frame_end
//   hue      hue_valid    hue_stall    pixel_hue
//
// One item is accepted per cycle while pixel_stall is low.
// The fixed-point pipeline holds the coordinate scale and constant dividers,
// a five-term Horner sine with a divider after each term, and the final hue scaling.
// Reset sets the phase step and hue offset to zero and empties the pipeline.
// Each stage holds its item while the next stage is stalled, so empty stages still fill.
`default_nettype none

module plasma_hue_generator import phg_pkg::*; #(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                pixel_valid,
  output logic               pixel_stall,
  input  wire  [COORD_W-1:0] column,
  input  wire  [COORD_W-1:0] row,
  input  wire                frame_end,
  output logic               hue_valid,
  input  wire                hue_stall,
  output logic [HUE_W-1:0]   pixel_hue
);

  logic [STEP_W-1:0] phase_step;
  logic [HUE_W-1:0]  hue_shift;

  logic              front_ready;
  logic              f_valid, f_ready;
  logic [ANG_W-1:0]  f_angle;
  logic              f_negate;
  logic [HUE_W-1:0]  f_shift;

  logic                     s_valid, s_ready;
  logic signed [SINE_W-1:0] s_sine;
  logic [HUE_W-1:0]         s_shift;

  logic              n_valid, n_ready, n_div_ready;
  logic [31:0]       n_num;
  logic [HUE_W-1:0]  n_shift;
  logic signed [17:0] biased;
  logic [31:0]       num_next;

  logic              d_valid, out_ready;
  logic [31:0]       d_quo;
  logic [HUE_W-1:0]  d_shift;

  logic accept;

  assign pixel_stall = !front_ready;
  assign accept      = pixel_valid && front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      hue_shift  <= '0;
    end else if (accept && frame_end) begin
      if (phase_step >= STEP_LAST) begin
        phase_step <= '0;
        hue_shift  <= hue_shift + SHIFT_INC;
      end else begin
        phase_step <= phase_step + 1'b1;
      end
    end
  end

  phg_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pixel_valid),
    .in_ready   (front_ready),
    .column     (column),
    .row        (row),
    .phase_step (phase_step),
    .hue_shift  (hue_shift),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .angle      (f_angle),
    .negate     (f_negate),
    .shift_out  (f_shift)
  );

  phg_sine u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .angle     (f_angle),
    .negate    (f_negate),
    .shift_in  (f_shift),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .sine      (s_sine),
    .shift_out (s_shift)
  );

  // The hue is 32767 * (sine + 98304) / 98304.
  assign biased   = 18'(s_sine) + HUE_BIAS;
  assign num_next = biased[16:0] * HUE_GAIN;

  assign n_ready = !n_valid || n_div_ready;
  assign s_ready = n_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (n_ready) begin
      n_valid <= s_valid;
    end
    if (n_ready && s_valid) begin
      n_num   <= num_next;
      n_shift <= s_shift;
    end
  end

  phg_cdiv #(
    .DIVISOR (HUE_DIV),
    .NUM_W   (32),
    .SIDE_W  (HUE_W)
  ) u_div_hue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n_valid),
    .in_ready  (n_div_ready),
    .num       (n_num),
    .side_in   (n_shift),
    .out_valid (d_valid),
    .out_ready (out_ready),
    .quo       (d_quo),
    .side_out  (d_shift)
  );

  assign out_ready = !hue_valid || !hue_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_valid <= 1'b0;
    end else if (out_ready) begin
      hue_valid <= d_valid;
    end
    if (out_ready && d_valid) begin
      pixel_hue <= d_quo[HUE_W-1:0] + d_shift;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_plasma_hue_generator.sv
// Self-checking testbench of the plasma hue generator with a fixed-point hue predictor.
`timescale 1ns / 1ps

module tb_plasma_hue_generator import phg_pkg::*; ();

  localparam int     COLS         = DEF_COLUMNS;
  localparam int     ROWS_N       = DEF_ROWS;
  localparam longint SCALE        = 7721;
  localparam int     FULL_TURN    = 25736;
  localparam int     HALF_TURN    = 12868;
  localparam int     QUARTER_TURN = 6434;
  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
  localparam int     LAST_STEP    = 200;
  localparam int     SHIFT_STEP   = 2048;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     LONG_HOLD    = 400;
  localparam int     RANDOM_ITEMS = 500;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               pixel_valid;
  logic               pixel_stall;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic               frame_end;
  logic               hue_valid;
  logic               hue_stall;
  logic [HUE_W-1:0]   pixel_hue;

  logic [HUE_W-1:0] pending_hues[$];
  int               cur_step;
  logic [HUE_W-1:0] cur_shift;
  int               fail_count = 0;
  int               burst_left = 0;
  bit               sender_gaps = 0;
  stall_mode_t      stall_mode = STALL_NONE;
  bit               hold_req = 0;

  plasma_hue_generator #(.COLUMNS(COLS), .ROWS(ROWS_N)) DUT (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .column(column),
    .row(row),
    .frame_end(frame_end),
    .hue_valid(hue_valid),
    .hue_stall(hue_stall),
    .pixel_hue(pixel_hue)
  );

  always #6 clk = ~clk;

  function automatic int sine_q15(input int angle);
    int r;
    bit neg;
    longint unsigned u, u2, t, q;
    r = angle % FULL_TURN;
    neg = 1'b0;
    if (r < 0) begin
      r += FULL_TURN;
    end
    if (r >= HALF_TURN) begin
      neg = 1'b1;
      r -= HALF_TURN;
    end
    if (r > QUARTER_TURN) begin
      r = HALF_TURN - r;
    end
    u = 64'(r);
    u = u << 18;
    u2 = (u * u) >> 30;
    t = UNIT_Q30 - u2 / 110;
    t = UNIT_Q30 - ((u2 * t) >> 30) / 72;
    t = UNIT_Q30 - ((u2 * t) >> 30) / 42;
    t = UNIT_Q30 - ((u2 * t) >> 30) / 20;
    t = UNIT_Q30 - ((u2 * t) >> 30) / 6;
    q = ((u * t) >> 30) >> 15;
    if (q > 32767) begin
      q = 32767;
    end
    return neg ? -int'(q) : int'(q);
  endfunction

  function automatic logic [HUE_W-1:0] plasma_hue(input int col, input int rw, input int step);
    longint d, p100, x, y, a, num;
    int s;
    d = 2 * longint'(step) - 200;
    p100 = 100 - ((d < 0) ? -d : d);
    x = (longint'(col) * p100 * SCALE) / (100 * longint'(COLS));
    y = -((longint'(rw) * p100 * SCALE) / (100 * longint'(ROWS_N)));
    a = (x * x - 2 * y * y) / 4096;
    if (a > 32767) begin
      a = 32767;
    end
    if (a < -32768) begin
      a = -32768;
    end
    s = sine_q15(int'(a));
    num = longint'(s) * 32767 + longint'(32767) * 98304;
    return HUE_W'(num / 98304);
  endfunction

  task automatic record_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                              input logic fe);
    pending_hues.push_back(plasma_hue(int'(c), int'(r), cur_step) + cur_shift);
    if (fe) begin
      if (cur_step >= LAST_STEP) begin
        cur_step = 0;
        cur_shift = cur_shift + HUE_W'(SHIFT_STEP);
      end else begin
        cur_step++;
      end
    end
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                            input logic fe);
    pixel_valid <= 1'b1;
    column <= c;
    row <= r;
    frame_end <= fe;
    @(posedge clk);
    while (pixel_stall !== 1'b0) @(posedge clk);
    record_pixel(c, r, fe);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        pixel_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_random_pixel(input logic fe);
    send_pixel(COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)), fe);
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (pending_hues.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_coordinate_corners();
    sender_gaps = 0;
    stall_mode = STALL_NONE;
    send_pixel(4'd0, 4'd0, 1'b0);
    send_pixel(4'd15, 4'd15, 1'b0);
    send_pixel(4'd15, 4'd0, 1'b0);
    send_pixel(4'd0, 4'd15, 1'b0);
    send_pixel(4'd8, 4'd8, 1'b0);
    for (int b = 0; b < COORD_W; b++) begin
      send_pixel(4'd1 << b, 4'd8 >> b, 1'b0);
    end
    send_pixel(4'd15, 4'd15, 1'b1);
    send_pixel(4'd15, 4'd15, 1'b0);
    send_pixel(4'd7, 4'd3, 1'b1);
    send_pixel(4'd0, 4'd0, 1'b1);
    send_pixel(4'd15, 4'd15, 1'b0);
    wait_drained();
  endtask

  task automatic test_phase_sweep();
    sender_gaps = 1;
    stall_mode = STALL_RANDOM;
    for (int k = 0; k < 2 * (LAST_STEP + 1) + 8; k++) begin
      send_random_pixel(1'b0);
      send_random_pixel(1'b1);
    end
    wait_drained();
  endtask

  task automatic test_random_pixels();
    int sent;
    int frame_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 250 == 0) begin
        sender_gaps = $urandom_range(0, 2) != 0;
        stall_mode = stall_mode_t'($urandom_range(0, 2));
      end
      case ($urandom_range(0, 9))
        0: begin
          send_random_pixel(1'($urandom_range(0, 1)));
          sent++;
        end
        1: begin
          for (int r = 0; r < ROWS_N; r++) begin
            for (int c = 0; c < COLS; c++) begin
              send_pixel(COORD_W'(c), COORD_W'(r), (r == ROWS_N - 1) && (c == COLS - 1));
            end
          end
          sent += COLS * ROWS_N;
        end
        default: begin
          frame_len = $urandom_range(1, 12);
          for (int i = 0; i < frame_len; i++) begin
            send_random_pixel(i == frame_len - 1);
          end
          sent += frame_len;
        end
      endcase
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    sender_gaps = 0;
    stall_mode = STALL_NONE;
    hold_req = 1;
    for (int i = 0; i < 80; i++) begin
      send_random_pixel($urandom_range(0, 3) == 0);
    end
    stall_mode = STALL_PERIODIC;
    for (int i = 0; i < 60; i++) begin
      send_random_pixel($urandom_range(0, 3) == 0);
    end
    wait_drained();
  endtask

  initial begin
    int period_count;
    hue_stall <= 1'b0;
    period_count = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hue_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end
      period_count = (period_count + 1) % 7;
      case (stall_mode)
        STALL_RANDOM:   hue_stall <= $urandom_range(0, 2) == 0;
        STALL_PERIODIC: hue_stall <= period_count < 3;
        default:        hue_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    logic [HUE_W-1:0] want;
    if (!rst && hue_valid === 1'b1 && hue_stall === 1'b0) begin
      if (pending_hues.size() == 0) begin
        $display("%0t: unexpected pixel_hue %h, expected none", $time, pixel_hue);
        fail_count++;
      end else begin
        want = pending_hues.pop_front();
        if (pixel_hue !== want) begin
          $display("%0t: pixel_hue mismatch, expected %h, actual %h", $time, want, pixel_hue);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    pixel_valid <= 1'b0;
    column <= '0;
    row <= '0;
    frame_end <= 1'b0;
    cur_step = 0;
    cur_shift = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_coordinate_corners();
    test_phase_sweep();
    test_random_pixels();
    test_output_backpressure();
    if (fail_count == 0 && pending_hues.size() == 0) begin
      $display("tb_plasma_hue_generator: PASS");
    end else begin
      $display("tb_plasma_hue_generator: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_plasma_hue_generator: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
sv/phg_pkg.sv
sv/phg_cdiv.sv
sv/phg_front.sv
sv/phg_sine.sv
sv/plasma_hue_generator.sv
bench/tb_plasma_hue_generator.sv
